// ===== design/smx_pkg.sv =====
// Shared types and constants of the stack machine execute core.
// Holds the transaction structs, opcode codes, fault codes and instruction classes.
// Depends on nothing.
`default_nettype none
package smx_pkg;

  localparam int NAME_COUNT = 256;
  localparam int NAME_W     = 8;
  localparam int ADDR_W     = 12;

  localparam logic [5:0] OP_LBL   = 6'd0;
  localparam logic [5:0] OP_PSH   = 6'd1;
  localparam logic [5:0] OP_PHV   = 6'd2;
  localparam logic [5:0] OP_POP   = 6'd3;
  localparam logic [5:0] OP_PPV   = 6'd4;
  localparam logic [5:0] OP_PTI   = 6'd5;
  localparam logic [5:0] OP_PTC   = 6'd6;
  localparam logic [5:0] OP_PTV   = 6'd7;
  localparam logic [5:0] OP_RDI   = 6'd9;
  localparam logic [5:0] OP_RDC   = 6'd10;
  localparam logic [5:0] OP_VAR   = 6'd11;
  localparam logic [5:0] OP_ADD   = 6'd12;
  localparam logic [5:0] OP_SUB   = 6'd13;
  localparam logic [5:0] OP_MUL   = 6'd14;
  localparam logic [5:0] OP_DIV   = 6'd15;
  localparam logic [5:0] OP_MOD   = 6'd16;
  localparam logic [5:0] OP_EQ    = 6'd17;
  localparam logic [5:0] OP_NE    = 6'd18;
  localparam logic [5:0] OP_GT    = 6'd19;
  localparam logic [5:0] OP_LT    = 6'd20;
  localparam logic [5:0] OP_GE    = 6'd21;
  localparam logic [5:0] OP_LE    = 6'd22;
  localparam logic [5:0] OP_LSH   = 6'd23;
  localparam logic [5:0] OP_RSH   = 6'd24;
  localparam logic [5:0] OP_LAND  = 6'd25;
  localparam logic [5:0] OP_LOR   = 6'd26;
  localparam logic [5:0] OP_BAND  = 6'd27;
  localparam logic [5:0] OP_BOR   = 6'd28;
  localparam logic [5:0] OP_XOR   = 6'd29;
  localparam logic [5:0] OP_LNOT  = 6'd30;
  localparam logic [5:0] OP_BNOT  = 6'd31;
  localparam logic [5:0] OP_EMPTY = 6'd32;
  localparam logic [5:0] OP_JMP   = 6'd33;
  localparam logic [5:0] OP_JIF   = 6'd34;
  localparam logic [5:0] OP_JEQ   = 6'd35;
  localparam logic [5:0] OP_JNE   = 6'd36;
  localparam logic [5:0] OP_JGT   = 6'd37;
  localparam logic [5:0] OP_JLT   = 6'd38;
  localparam logic [5:0] OP_JGE   = 6'd39;
  localparam logic [5:0] OP_JLE   = 6'd40;
  localparam logic [5:0] OP_LEFT  = 6'd41;
  localparam logic [5:0] OP_RIGHT = 6'd42;

  localparam logic [2:0] FLT_NONE  = 3'd0;
  localparam logic [2:0] FLT_UNDER = 3'd1;
  localparam logic [2:0] FLT_OVER  = 3'd2;
  localparam logic [2:0] FLT_DIV0  = 3'd3;
  localparam logic [2:0] FLT_HEAP  = 3'd4;

  typedef enum logic [3:0] {
    CL_LDEF, CL_NOP, CL_PUSH, CL_PHV, CL_POP, CL_PPV, CL_PRT, CL_PTV,
    CL_VAR, CL_BIN, CL_DIV, CL_UNI, CL_JMP, CL_JIF, CL_CJ, CL_MOVB
  } smx_class_t;

  typedef struct packed {
    logic               action;
    logic [5:0]         opcode;
    logic signed [31:0] operand_a;
    logic [12:0]        operand_b;
    logic [11:0]        instr_addr;
    logic signed [31:0] read_value;
  } smx_in_t;

  typedef struct packed {
    logic [11:0]        next_addr;
    logic               print_valid;
    logic               print_is_char;
    logic signed [31:0] print_value;
    logic [2:0]         fault;
  } smx_out_t;

  typedef struct packed {
    smx_in_t    item;
    smx_class_t cls;
    logic [1:0] len;
  } smx_uop_t;

endpackage
`default_nettype wire

// ===== design/smx_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module smx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/smx_div.sv =====
// Iterative signed divider: one quotient bit per cycle, truncating toward zero.
// Depends on nothing.
`default_nettype none
module smx_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  input  wire logic        want_rem,
  output logic             done,
  output logic      [31:0] result
);

  logic        run_r, done_r, negq_r, negr_r, want_r;
  logic [4:0]  cnt_r;
  logic [31:0] q_r, d_r;
  logic [32:0] rem_r;
  logic [32:0] rem_sh, rem_sub;
  logic        take;

  always_comb begin
    rem_sh  = {rem_r[31:0], q_r[31]};
    rem_sub = rem_sh - {1'b0, d_r};
    take    = (rem_sh >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        cnt_r  <= 5'd31;
        negq_r <= dividend[31] ^ divisor[31];
        negr_r <= dividend[31];
        want_r <= want_rem;
        q_r    <= dividend[31] ? (32'd0 - dividend) : dividend;
        d_r    <= divisor[31] ? (32'd0 - divisor) : divisor;
        rem_r  <= '0;
      end else if (run_r) begin
        rem_r <= take ? rem_sub : rem_sh;
        q_r   <= {q_r[30:0], take};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = want_r ? (negr_r ? (32'd0 - rem_r[31:0]) : rem_r[31:0])
                         : (negq_r ? (32'd0 - q_r) : q_r);

endmodule
`default_nettype wire

// ===== design/smx_front.sv =====
// Front end: accepts transactions, classifies them and queues them for the back end.
// Depends on smx_pkg.
`default_nettype none
module smx_front
  import smx_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire smx_in_t  in_data,
  output logic          busy,
  output logic          q_valid,
  output smx_uop_t      q_head,
  input  wire logic     q_pop
);

  smx_uop_t   ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  smx_uop_t   uop;
  logic       push;

  always_comb begin
    uop.item = in_data;
    uop.cls  = CL_NOP;
    uop.len  = 2'd1;
    if (!in_data.action) begin
      uop.cls = CL_LDEF;
    end else begin
      case (in_data.opcode)
        OP_LBL:                     uop.len = 2'd2;
        OP_PSH:                     begin uop.cls = CL_PUSH; uop.len = 2'd2; end
        OP_RDI, OP_RDC, OP_EMPTY:   uop.cls = CL_PUSH;
        OP_PHV:                     begin uop.cls = CL_PHV; uop.len = 2'd2; end
        OP_POP:                     uop.cls = CL_POP;
        OP_PPV:                     begin uop.cls = CL_PPV; uop.len = 2'd2; end
        OP_PTI, OP_PTC:             uop.cls = CL_PRT;
        OP_PTV:                     begin uop.cls = CL_PTV; uop.len = 2'd2; end
        OP_VAR:                     begin uop.cls = CL_VAR; uop.len = 2'd3; end
        OP_DIV, OP_MOD:             uop.cls = CL_DIV;
        OP_LNOT, OP_BNOT:           uop.cls = CL_UNI;
        OP_JMP:                     begin uop.cls = CL_JMP; uop.len = 2'd2; end
        OP_JIF:                     begin uop.cls = CL_JIF; uop.len = 2'd2; end
        OP_LEFT, OP_RIGHT:          begin uop.cls = CL_MOVB; uop.len = 2'd2; end
        default: begin
          if (in_data.opcode >= OP_ADD && in_data.opcode <= OP_XOR) begin
            uop.cls = CL_BIN;
          end else if (in_data.opcode >= OP_JEQ && in_data.opcode <= OP_JLE) begin
            uop.cls = CL_CJ;
            uop.len = 2'd2;
          end
        end
      endcase
    end
  end

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        ent_r[wp_r] <= uop;
        wp_r        <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule
`default_nettype wire

// ===== design/smx_back.sv =====
// Back end: executes queued instructions against stack, heap, name and label stores.
// Depends on smx_pkg, smx_ram and smx_div.
`default_nettype none
module smx_back
  import smx_pkg::*;
#(
  parameter int STACK_DEPTH = 64,
  parameter int HEAP_WORDS  = 4096
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_valid,
  input  wire smx_uop_t q_head,
  output logic          q_pop,
  output logic          out_valid,
  output smx_out_t      out_data
);

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam int HAW = $clog2(HEAP_WORDS);
  localparam int HCW = $clog2(HEAP_WORDS + 1);

  typedef enum logic [2:0] {S_IDLE, S_EX, S_HP, S_DV, S_FX} state_t;

  state_t          st_r, st_nxt;
  smx_uop_t        cur_r, cur_nxt;
  logic [SCW-1:0]  cnt_r, cnt_nxt;
  logic [31:0]     tos_r, tos_nxt;
  logic [HCW-1:0]  hnf_r, hnf_nxt;
  logic [NAME_COUNT-1:0] nv_r, nv_nxt, lv_r, lv_nxt;
  logic            nrv_r, nrv_nxt, lrv_r, lrv_nxt;
  logic            out_valid_r, out_valid_nxt;
  smx_out_t        res_r, res_nxt;

  logic            stk_we;
  logic [SAW-1:0]  stk_waddr, stk_raddr;
  logic [31:0]     stk_wdata, stk_rd;
  logic            hp_we;
  logic [HAW-1:0]  hp_addr;
  logic [31:0]     hp_wdata, hp_rd;
  logic            nm_we;
  logic [31:0]     nm_wdata, nm_rd;
  logic            lb_we;
  logic [11:0]     lb_rd;
  logic [NAME_W-1:0] rname, cname;
  logic            div_start, div_done;
  logic [31:0]     div_q;

  logic [SCW-1:0]  nm1, nm2, nm3;
  logic [31:0]     base, a_u, vsum;
  logic [11:0]     lbl, seq, jt;
  logic [5:0]      op;

  function automatic logic [31:0] binop(input logic [5:0] o, input logic [31:0] l,
                                        input logic [31:0] r);
    logic [31:0] v;
    case (o)
      OP_ADD:  v = l + r;
      OP_SUB:  v = l - r;
      OP_MUL:  v = l * r;
      OP_EQ:   v = {31'd0, l == r};
      OP_NE:   v = {31'd0, l != r};
      OP_GT:   v = {31'd0, $signed(l) > $signed(r)};
      OP_LT:   v = {31'd0, $signed(l) < $signed(r)};
      OP_GE:   v = {31'd0, $signed(l) >= $signed(r)};
      OP_LE:   v = {31'd0, $signed(l) <= $signed(r)};
      OP_LSH:  v = l << r[4:0];
      OP_RSH:  v = $unsigned($signed(l) >>> r[4:0]);
      OP_LAND: v = {31'd0, (l != 0) && (r != 0)};
      OP_LOR:  v = {31'd0, (l != 0) || (r != 0)};
      OP_BAND: v = l & r;
      OP_BOR:  v = l | r;
      default: v = l ^ r;
    endcase
    return v;
  endfunction

  function automatic logic cmpj(input logic [5:0] o, input logic [31:0] l,
                                input logic [31:0] r);
    logic t;
    case (o)
      OP_JEQ:  t = (l == r);
      OP_JNE:  t = (l != r);
      OP_JGT:  t = $signed(l) > $signed(r);
      OP_JLT:  t = $signed(l) < $signed(r);
      OP_JGE:  t = $signed(l) >= $signed(r);
      default: t = $signed(l) <= $signed(r);
    endcase
    return t;
  endfunction

  smx_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rd));

  smx_ram #(.WIDTH(32), .DEPTH(HEAP_WORDS)) u_heap (
    .clk(clk), .we(hp_we), .waddr(hp_addr), .wdata(hp_wdata),
    .raddr(hp_addr), .rdata(hp_rd));

  smx_ram #(.WIDTH(32), .DEPTH(NAME_COUNT)) u_names (
    .clk(clk), .we(nm_we), .waddr(cname), .wdata(nm_wdata),
    .raddr(rname), .rdata(nm_rd));

  smx_ram #(.WIDTH(ADDR_W), .DEPTH(NAME_COUNT)) u_labels (
    .clk(clk), .we(lb_we), .waddr(cname), .wdata(cur_r.item.instr_addr),
    .raddr(rname), .rdata(lb_rd));

  smx_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(stk_rd),
    .divisor(tos_r), .want_rem(cur_r.item.opcode == OP_MOD),
    .done(div_done), .result(div_q));

  always_comb begin
    st_nxt        = st_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    tos_nxt       = tos_r;
    hnf_nxt       = hnf_r;
    nv_nxt        = nv_r;
    lv_nxt        = lv_r;
    res_nxt       = res_r;
    out_valid_nxt = 1'b0;
    q_pop         = 1'b0;
    stk_we        = 1'b0;
    hp_we         = 1'b0;
    nm_we         = 1'b0;
    lb_we         = 1'b0;
    div_start     = 1'b0;
    nm_wdata      = '0;
    hp_wdata      = tos_r;

    op    = cur_r.item.opcode;
    a_u   = $unsigned(cur_r.item.operand_a);
    cname = a_u[NAME_W-1:0];
    rname = q_head.item.operand_a[NAME_W-1:0];
    nm1   = cnt_r - SCW'(1);
    nm2   = cnt_r - SCW'(2);
    nm3   = cnt_r - SCW'(3);
    stk_waddr = nm1[SAW-1:0];
    stk_wdata = tos_r;
    stk_raddr = nm2[SAW-1:0];
    base  = nrv_r ? nm_rd : 32'd0;
    lbl   = lrv_r ? lb_rd : 12'd0;
    seq   = cur_r.item.instr_addr + {10'd0, cur_r.len};
    jt    = lbl + 12'd1;
    hp_addr = base[HAW-1:0];
    vsum  = 32'(hnf_r) + 32'(cur_r.item.operand_b);
    nrv_nxt = nv_r[rname];
    lrv_nxt = lv_r[rname];

    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cur_nxt = q_head;
          st_nxt  = S_EX;
        end
      end
      S_EX: begin
        res_nxt       = '{next_addr: seq, print_valid: 1'b0, print_is_char: 1'b0,
                          print_value: '0, fault: FLT_NONE};
        out_valid_nxt = 1'b1;
        st_nxt        = S_IDLE;
        case (cur_r.cls)
          CL_LDEF: begin
            lb_we         = 1'b1;
            lv_nxt[cname] = 1'b1;
          end
          CL_PUSH: begin
            if (cnt_r >= SCW'(STACK_DEPTH)) begin
              res_nxt.fault = FLT_OVER;
            end else begin
              stk_we  = (cnt_r != '0);
              tos_nxt = (op == OP_PSH) ? a_u :
                        (op == OP_EMPTY) ? {31'd0, cnt_r == '0} :
                        $unsigned(cur_r.item.read_value);
              cnt_nxt = cnt_r + SCW'(1);
            end
          end
          CL_PHV: begin
            if (cnt_r >= SCW'(STACK_DEPTH)) begin
              res_nxt.fault = FLT_OVER;
            end else if (base >= 32'(HEAP_WORDS)) begin
              res_nxt.fault = FLT_HEAP;
            end else begin
              out_valid_nxt = 1'b0;
              st_nxt        = S_HP;
            end
          end
          CL_POP: begin
            if (cnt_r == '0) begin
              res_nxt.fault = FLT_UNDER;
            end else begin
              cnt_nxt = nm1;
              tos_nxt = stk_rd;
            end
          end
          CL_PPV: begin
            if (cnt_r == '0) begin
              res_nxt.fault = FLT_UNDER;
            end else if (base >= 32'(HEAP_WORDS)) begin
              res_nxt.fault = FLT_HEAP;
            end else begin
              hp_we   = 1'b1;
              cnt_nxt = nm1;
              tos_nxt = stk_rd;
            end
          end
          CL_PRT: begin
            if (cnt_r == '0) begin
              res_nxt.fault = FLT_UNDER;
            end else begin
              res_nxt.print_valid   = 1'b1;
              res_nxt.print_is_char = (op == OP_PTC);
              res_nxt.print_value   = (op == OP_PTC) ? {24'd0, tos_r[7:0]} : tos_r;
            end
          end
          CL_PTV: begin
            if (base >= 32'(HEAP_WORDS)) begin
              res_nxt.fault = FLT_HEAP;
            end else begin
              out_valid_nxt = 1'b0;
              st_nxt        = S_HP;
            end
          end
          CL_VAR: begin
            if (vsum > 32'(HEAP_WORDS)) begin
              res_nxt.fault = FLT_HEAP;
            end else begin
              nm_we         = 1'b1;
              nm_wdata      = 32'(hnf_r);
              nv_nxt[cname] = 1'b1;
              hnf_nxt       = vsum[HCW-1:0];
            end
          end
          CL_BIN: begin
            if (cnt_r < SCW'(2)) begin
              res_nxt.fault = FLT_UNDER;
            end else begin
              tos_nxt = binop(op, stk_rd, tos_r);
              cnt_nxt = nm1;
            end
          end
          CL_DIV: begin
            if (cnt_r < SCW'(2)) begin
              res_nxt.fault = FLT_UNDER;
            end else if (tos_r == 32'd0) begin
              res_nxt.fault = FLT_DIV0;
            end else begin
              div_start     = 1'b1;
              out_valid_nxt = 1'b0;
              st_nxt        = S_DV;
            end
          end
          CL_UNI: begin
            if (cnt_r == '0) begin
              res_nxt.fault = FLT_UNDER;
            end else begin
              tos_nxt = (op == OP_LNOT) ? {31'd0, tos_r == 32'd0} : ~tos_r;
            end
          end
          CL_JMP: begin
            res_nxt.next_addr = jt;
          end
          CL_JIF: begin
            if (cnt_r == '0) begin
              res_nxt.fault = FLT_UNDER;
            end else begin
              if (tos_r != 32'd0) begin
                res_nxt.next_addr = jt;
              end
              cnt_nxt = nm1;
              tos_nxt = stk_rd;
            end
          end
          CL_CJ: begin
            if (cnt_r < SCW'(2)) begin
              res_nxt.fault = FLT_UNDER;
            end else begin
              if (cmpj(op, stk_rd, tos_r)) begin
                res_nxt.next_addr = jt;
              end
              cnt_nxt = nm2;
              if (cnt_r > SCW'(2)) begin
                // refill top of stack from the entry below both operands
                stk_raddr     = nm3[SAW-1:0];
                out_valid_nxt = 1'b0;
                st_nxt        = S_FX;
              end
            end
          end
          CL_MOVB: begin
            if (cnt_r == '0) begin
              res_nxt.fault = FLT_UNDER;
            end else begin
              nm_we         = 1'b1;
              nm_wdata      = (op == OP_LEFT) ? (base - tos_r) : (base + tos_r);
              nv_nxt[cname] = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_HP: begin
        out_valid_nxt = 1'b1;
        st_nxt        = S_IDLE;
        if (cur_r.cls == CL_PHV) begin
          stk_we  = (cnt_r != '0);
          tos_nxt = hp_rd;
          cnt_nxt = cnt_r + SCW'(1);
        end else begin
          res_nxt.print_valid = 1'b1;
          res_nxt.print_value = hp_rd;
        end
      end
      S_DV: begin
        if (div_done) begin
          tos_nxt       = div_q;
          cnt_nxt       = nm1;
          out_valid_nxt = 1'b1;
          st_nxt        = S_IDLE;
        end
      end
      S_FX: begin
        tos_nxt       = stk_rd;
        out_valid_nxt = 1'b1;
        st_nxt        = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      hnf_r       <= '0;
      nv_r        <= '0;
      lv_r        <= '0;
      nrv_r       <= 1'b0;
      lrv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      hnf_r       <= hnf_nxt;
      nv_r        <= nv_nxt;
      lv_r        <= lv_nxt;
      nrv_r       <= nrv_nxt;
      lrv_r       <= lrv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r <= cur_nxt;
    tos_r <= tos_nxt;
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

endmodule
`default_nettype wire

// ===== design/stack_machine_execute_core.sv =====
// Top level of the stack machine execute core.
// Depends on smx_pkg, smx_front and smx_back (which uses smx_ram and smx_div).
`default_nettype none
// One transaction in, one result out. A transaction is taken when start is
// high and busy is low; busy only rises when the two-entry instruction queue
// between the front end and the back end is full. Each result appears on
// out_data for exactly one cycle with out_valid high and cannot be held off,
// so capture it on that edge. In the back end most instructions first read
// the stack, name and label stores, then execute and register the result.
// Heap loads and variable prints (phv, ptv) add a heap RAM read, which sits
// behind the name table read. Compare-jumps that leave a nonempty stack add
// one more stack RAM read to refill the cached top of stack. Division and
// modulo wait on the one-bit-per-cycle divider. Results come out in
// transaction order.
module stack_machine_execute_core
  import smx_pkg::*;
#(
  parameter int STACK_DEPTH = 64,
  parameter int HEAP_WORDS  = 4096
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire smx_in_t in_data,
  output logic         busy,
  output logic         out_valid,
  output smx_out_t     out_data
);

  logic     q_valid, q_pop;
  smx_uop_t q_head;

  // Front end: classify and queue each accepted transaction.
  smx_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .in_data(in_data), .busy(busy),
    .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop));

  // Back end: execute one queued instruction at a time.
  smx_back #(.STACK_DEPTH(STACK_DEPTH), .HEAP_WORDS(HEAP_WORDS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
    .out_valid(out_valid), .out_data(out_data));

`ifndef SYNTHESIS
  // Every instruction passes through S_IDLE before S_EX, so results are never back to back.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("results on consecutive cycles");

  a_fault_no_print: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.fault != FLT_NONE) |-> !out_data.print_valid)
    else $error("faulting instruction printed");

  a_quiet_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.print_valid) |->
      (out_data.print_value == 32'sd0 && !out_data.print_is_char))
    else $error("print fields set without print");
`endif

endmodule
`default_nettype wire
